/* hdl/hdlctx_pkg.sv */
// shared types and constants for the hdlc transmit zero-bit insertion framer
`timescale 1ns / 1ps

package hdlctx_pkg;

  localparam int unsigned WORD_MAX = 16;
  localparam int unsigned SRC_W    = 24;
  localparam int unsigned POS_W    = 5;
  localparam int unsigned CNT_W    = 5;

  localparam logic [7:0]       FLAG_OCTET  = 8'h7E;
  localparam logic [SRC_W-1:0] FRAME_FLAGS = 24'h7E7E7E;
  localparam logic [4:0]       ONES_RUN    = 5'h1F;

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_PULL = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_BIT,
    S_LOAD,
    S_DONE
  } state_t;

  // control from the sequencer to the bit serializer
  typedef struct packed {
    logic load_idle;
    logic load_frame;
    logic load_octet;
    logic step;
  } ser_ctl_t;

  // status back from the bit serializer
  typedef struct packed {
    logic        empty;
    logic [15:0] hist;
  } ser_stat_t;

endpackage

/* hdl/hdlc_tx_bit_stuff_packer_top.sv */
// top level of the hdlc transmit framer with zero-bit insertion
`timescale 1ns / 1ps
//
// usage:
//   input channel (in_valid / in_stall) carries command and element.
//   command push stores element (frame length or data octet) in the ring;
//   the result says whether it was stored (0 when the ring is full).
//   command pull packs the next word_width line bits, earliest bit highest,
//   into out_word; idle_inserted flags that the ring ran dry and idle flags
//   were sent. every item returns one result with the ring level after it.
//   a length element sends three flag octets, then its data octets msb first.
//   config: cfg_we / cfg_data write word_width (0 acts as 1, above 16 as 16)
//   a push result is registered after the item is taken; a pull result after
//   the line bits are shifted out (stuffed zeros included), idle flags loaded
//   and ring elements read (empty check, then registered memory port), then
//   the done state. one item at a time, the next taken once its result loads.
//   a finished result sits in the output register until taken; a stalled
//   receiver holds the result and the block waits before writing the next.
//   reset (rst, synchronous): ring empty, pointers zero, bit history clear,
//   word_width back to 8. ring contents are not cleared.
//
module hdlc_tx_bit_stuff_packer_top
  import hdlctx_pkg::*;
#(
  parameter int unsigned RING_DEPTH = 256
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [4:0]                        cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              command,
  input  logic [15:0]                       element,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              accepted,
  output logic [15:0]                       out_word,
  output logic                              idle_inserted,
  output logic [$clog2(RING_DEPTH+1)-1:0]   ring_level
);

  localparam int unsigned PTR_W = $clog2(RING_DEPTH);
  localparam int unsigned OCC_W = $clog2(RING_DEPTH + 1);

  state_t           state, state_next;
  ser_ctl_t         ser_ctl;
  ser_stat_t        ser_stat;

  logic [15:0]      ring [RING_DEPTH];
  logic [15:0]      rd_data;
  logic [PTR_W-1:0] rd_ptr, wr_ptr;
  logic [OCC_W-1:0] occ;
  logic [15:0]      octets_left;
  logic [CNT_W-1:0] bit_cnt, bit_cnt_next;
  logic [4:0]       word_width;
  logic [CNT_W-1:0] w_eff;
  logic [15:0]      word_mask;

  logic             res_accepted;
  logic             res_pull;
  logic             res_idle;
  logic             in_take, ring_full, ring_write, ring_read, out_load;

  // clamp the configured width into 1..16
  always_comb begin
    priority if (word_width == '0) w_eff = CNT_W'(1);
    else if (word_width > 5'(WORD_MAX)) w_eff = CNT_W'(WORD_MAX);
    else w_eff = CNT_W'(word_width);
  end

  assign word_mask    = ~(16'hFFFF << w_eff);
  assign in_stall     = (state != S_IDLE);
  assign in_take      = in_valid && !in_stall;
  assign ring_full    = (occ == OCC_W'(RING_DEPTH));
  assign ring_write   = in_take && (command == CMD_PUSH) && !ring_full;
  assign ring_read    = (state == S_LOAD);
  assign bit_cnt_next = bit_cnt + CNT_W'(1);
  assign out_load     = (state == S_DONE) && (!out_valid || !out_stall);

  // sequencer: next state and serializer control
  always_comb begin
    state_next = state;
    ser_ctl    = '0;
    unique case (state)
      S_IDLE: begin
        if (in_take) begin
          state_next = (command == CMD_PULL) ? S_BIT : S_DONE;
        end
      end
      S_BIT: begin
        if (ser_stat.empty) begin
          // source used up: next ring element, or an idle flag when empty
          if (occ == '0) begin
            ser_ctl.load_idle = 1'b1;
          end else begin
            state_next = S_LOAD;
          end
        end else begin
          ser_ctl.step = 1'b1;
          if (bit_cnt_next == w_eff) begin
            state_next = S_DONE;
          end
        end
      end
      S_LOAD: begin
        if (octets_left != '0) begin
          ser_ctl.load_octet = 1'b1;
        end else begin
          ser_ctl.load_frame = 1'b1;
        end
        state_next = S_BIT;
      end
      S_DONE: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // ring memory, registered read at the read pointer
  always_ff @(posedge clk) begin
    if (ring_write) begin
      ring[wr_ptr] <= element;
    end
    rd_data <= ring[rd_ptr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr      <= '0;
      wr_ptr      <= '0;
      occ         <= '0;
      octets_left <= '0;
      bit_cnt     <= '0;
      word_width  <= 5'd8;
    end else begin
      if (cfg_we) begin
        word_width <= cfg_data;
      end
      if (ring_write) begin
        wr_ptr <= (wr_ptr == PTR_W'(RING_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
        occ    <= occ + OCC_W'(1);
      end
      if (ring_read) begin
        rd_ptr <= (rd_ptr == PTR_W'(RING_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
        occ    <= occ - OCC_W'(1);
        if (octets_left != '0) begin
          octets_left <= octets_left - 16'd1;
        end else begin
          octets_left <= rd_data;
        end
      end
      if (in_take) begin
        bit_cnt <= '0;
      end else if (ser_ctl.step) begin
        bit_cnt <= (bit_cnt_next == w_eff) ? '0 : bit_cnt_next;
      end
    end
  end

  // per-item result flags
  always_ff @(posedge clk) begin
    if (in_take) begin
      res_accepted <= ring_write;
      res_pull     <= (command == CMD_PULL);
      res_idle     <= 1'b0;
    end else if (ser_ctl.load_idle) begin
      res_idle <= 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      accepted      <= res_accepted;
      idle_inserted <= res_idle;
      // push items, stored or refused, carry no line bits
      out_word      <= res_pull ? (ser_stat.hist & word_mask) : 16'h0000;
      ring_level    <= occ;
    end
  end

  hdlctx_serializer u_ser (
    .clk   (clk),
    .rst   (rst),
    .ctl   (ser_ctl),
    .octet (rd_data[7:0]),
    .stat  (ser_stat)
  );

`ifndef SYNTHESIS
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= OCC_W'(RING_DEPTH))
    else $error("ring occupancy above depth");

  a_load_nonempty: assert property (@(posedge clk) disable iff (rst)
    state == S_LOAD |-> occ != '0)
    else $error("ring read while empty");

  a_load_fills: assert property (@(posedge clk) disable iff (rst)
    state == S_LOAD |=> !ser_stat.empty)
    else $error("serializer empty after load");

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_BIT |-> bit_cnt < w_eff)
    else $error("bit count past word width");

  a_no_write_busy: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |=> $stable(wr_ptr))
    else $error("ring written during an item");
`endif

endmodule

/* hdl/hdlctx_serializer.sv */
// source shift register, line bit history and zero-bit insertion
`timescale 1ns / 1ps

module hdlctx_serializer
  import hdlctx_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  ser_ctl_t  ctl,
  input  logic [7:0] octet,
  output ser_stat_t stat
);

  logic [SRC_W-1:0] src;
  logic [POS_W-1:0] pos;
  logic             flag;
  logic [15:0]      hist;
  logic [15:0]      hist_next;
  logic             stuff;

  assign hist_next = {hist[14:0], src[SRC_W-1]};
  // five ones in a row from data: send a zero before the next source bit
  assign stuff     = !flag && (hist_next[4:0] == ONES_RUN);

  always_ff @(posedge clk) begin
    if (rst) begin
      pos  <= '0;
      flag <= 1'b0;
      hist <= '0;
    end else begin
      priority if (ctl.load_idle) begin
        src  <= {FLAG_OCTET, 16'h0000};
        pos  <= POS_W'(8);
        flag <= 1'b1;
      end else if (ctl.load_frame) begin
        src  <= FRAME_FLAGS;
        pos  <= POS_W'(SRC_W);
        flag <= 1'b1;
      end else if (ctl.load_octet) begin
        src  <= {octet, 16'h0000};
        pos  <= POS_W'(8);
        flag <= 1'b0;
      end else if (ctl.step) begin
        hist <= hist_next;
        if (stuff) begin
          src[SRC_W-1] <= 1'b0;
        end else begin
          src <= {src[SRC_W-2:0], 1'b0};
          pos <= pos - POS_W'(1);
        end
      end
    end
  end

  assign stat.empty = (pos == '0);
  assign stat.hist  = hist;

endmodule
